// File: design/hmca_pkg.sv
// Shared types and constants of the minimum-cost assignment block.
package hmca_pkg;

    localparam int COST_FIELD_WIDTH = 32;
    localparam int CFG_WIDTH        = 5;
    localparam int OUT_INDEX_WIDTH  = 4;
    localparam int STATUS_WIDTH     = 2;

    localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_SHAPE    = 2'd2;

    localparam logic CFG_ROWS    = 1'b0;
    localparam logic CFG_COLUMNS = 1'b1;

    typedef struct packed {
        logic                 bad;
        logic [CFG_WIDTH-1:0] rows;
        logic [CFG_WIDTH-1:0] columns;
    } job_t;

endpackage

// File: design/hmca_channels.sv
// Item channels of the minimum-cost assignment block.
interface hmca_in_if import hmca_pkg::*; ();
    logic                               valid;
    logic                               ready;
    logic signed [COST_FIELD_WIDTH-1:0] cost;
    logic                               last_entry;

    modport source (output valid, cost, last_entry, input ready);
    modport sink (input valid, cost, last_entry, output ready);
endinterface

interface hmca_out_if import hmca_pkg::*; ();
    logic                               valid;
    logic                               ready;
    logic [OUT_INDEX_WIDTH-1:0]         row_index;
    logic [OUT_INDEX_WIDTH-1:0]         assigned_column;
    logic signed [COST_FIELD_WIDTH-1:0] total_cost;
    logic [STATUS_WIDTH-1:0]            status;
    logic                               last_result;

    modport source (output valid, row_index, assigned_column, total_cost, status, last_result,
                    input ready);
    modport sink (input valid, row_index, assigned_column, total_cost, status, last_result,
                  output ready);
endinterface

// File: design/hmca_front.sv
// Loader: takes cost items into the matrix store and classifies each finished matrix.
module hmca_front import hmca_pkg::*; #(
    parameter int MAX_ROWS    = 16,
    parameter int MAX_COLUMNS = 16,
    parameter int COST_WIDTH  = 32,
    parameter int DEPTH       = MAX_ROWS * MAX_COLUMNS,
    parameter int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    hmca_in_if.sink                      in_ch,
    input  logic [CFG_WIDTH-1:0]         rows_in_use,
    input  logic [CFG_WIDTH-1:0]         columns_in_use,
    input  logic                         back_busy,
    input  logic                         queue_empty,
    output logic                         push_valid,
    output job_t                         push_job,
    input  logic [AW-1:0]                rd_addr,
    output logic signed [COST_WIDTH-1:0] rd_data
);

    localparam int LW   = $clog2(DEPTH + 2);
    localparam int CMPW = (LW > 2 * CFG_WIDTH) ? LW : 2 * CFG_WIDTH;

    logic signed [COST_WIDTH-1:0] mem_reg [DEPTH];
    logic signed [COST_WIDTH-1:0] rd_data_reg;
    logic [LW-1:0]                count_reg;
    logic [LW-1:0]                count_next;
    logic [LW-1:0]                count_inc;
    logic signed [COST_WIDTH-1:0] cost_w;
    logic                         accept;
    logic                         shape_bad;

    assign in_ch.ready = !back_busy && queue_empty;
    assign accept      = in_ch.valid && in_ch.ready;
    assign cost_w      = COST_WIDTH'(in_ch.cost);
    assign count_inc   = (count_reg <= LW'(DEPTH)) ? count_reg + LW'(1) : count_reg;

    assign shape_bad = (rows_in_use == '0) || (rows_in_use > MAX_ROWS) ||
                       (columns_in_use == '0) || (columns_in_use > MAX_COLUMNS) ||
                       (rows_in_use > columns_in_use) ||
                       (CMPW'(count_inc) != CMPW'(rows_in_use) * CMPW'(columns_in_use));

    assign push_valid       = accept && in_ch.last_entry;
    assign push_job.bad     = shape_bad;
    assign push_job.rows    = rows_in_use;
    assign push_job.columns = columns_in_use;

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = in_ch.last_entry ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (count_reg < LW'(DEPTH)))
        begin
            mem_reg[count_reg[AW-1:0]] <= cost_w;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/hmca_job_queue.sv
// Two-entry queue of classified matrices between loader and solver.
module hmca_job_queue import hmca_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: design/hmca_back.sv
// Solver: potential-based shortest augmenting paths, then per-row result items.
module hmca_back import hmca_pkg::*; #(
    parameter int MAX_ROWS    = 16,
    parameter int MAX_COLUMNS = 16,
    parameter int COST_WIDTH  = 32,
    parameter int DEPTH       = MAX_ROWS * MAX_COLUMNS,
    parameter int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    output logic                         job_pop,
    input  job_t                         job,
    output logic                         busy,
    output logic [AW-1:0]                rd_addr,
    input  logic signed [COST_WIDTH-1:0] rd_data,
    hmca_out_if.source                   out_ch
);

    localparam int W    = COST_WIDTH;
    localparam int CW   = $clog2(MAX_COLUMNS + 1);
    localparam int RW   = $clog2(MAX_ROWS + 1);
    localparam int RI   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MAXD = (MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;
    localparam int KW   = $clog2(MAXD + 2);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CLR  = 5'd1;
    localparam logic [4:0] S_ROWI = 5'd2;
    localparam logic [4:0] S_STEP = 5'd3;
    localparam logic [4:0] S_SCA  = 5'd4;
    localparam logic [4:0] S_SCB  = 5'd5;
    localparam logic [4:0] S_SCC  = 5'd6;
    localparam logic [4:0] S_DEC  = 5'd7;
    localparam logic [4:0] S_UPC  = 5'd8;
    localparam logic [4:0] S_UPR  = 5'd9;
    localparam logic [4:0] S_TEST = 5'd10;
    localparam logic [4:0] S_FLIP = 5'd11;
    localparam logic [4:0] S_ASGN = 5'd12;
    localparam logic [4:0] S_SUMA = 5'd13;
    localparam logic [4:0] S_SUMB = 5'd14;
    localparam logic [4:0] S_EMIT = 5'd15;
    localparam logic [4:0] S_ERR  = 5'd16;

    function automatic logic [W:0] add_ext(input logic signed [W-1:0] a,
                                           input logic signed [W-1:0] b);
        add_ext = {a[W-1], a} + {b[W-1], b};
    endfunction

    function automatic logic [W:0] sub_ext(input logic signed [W-1:0] a,
                                           input logic signed [W-1:0] b);
        sub_ext = {a[W-1], a} - {b[W-1], b};
    endfunction

    logic signed [W-1:0] u_reg     [MAX_ROWS + 1];
    logic signed [W-1:0] v_reg     [MAX_COLUMNS + 1];
    logic signed [W-1:0] slack_reg [MAX_COLUMNS + 1];
    logic [RW-1:0]       owner_reg [MAX_COLUMNS + 1];
    logic [CW-1:0]       pred_reg  [MAX_COLUMNS + 1];
    logic [CW-1:0]       col_of_row_reg [MAX_ROWS];
    logic [MAX_COLUMNS:0] valid_reg;
    logic [MAX_COLUMNS:0] visited_reg;
    logic [MAX_ROWS:0]    tree_reg;
    logic                have_reg;
    logic signed [W-1:0] delta_reg;
    logic [CW-1:0]       next_reg;
    logic signed [W-1:0] t_reg;
    logic signed [W-1:0] total_reg;

    logic [4:0]              state_reg, state_next;
    logic [KW-1:0]           k_reg, k_next;
    logic [RW-1:0]           row_reg, row_next;
    logic [CW-1:0]           cur_reg, cur_next;
    logic [RW-1:0]           crow_reg, crow_next;
    logic [STATUS_WIDTH-1:0] stat_reg, stat_next;
    logic [RW-1:0]           nr_reg, nr_next;
    logic [CW-1:0]           nc_reg, nc_next;
    logic                    ovalid_reg, ovalid_next;

    logic [OUT_INDEX_WIDTH-1:0]         orow_reg;
    logic [OUT_INDEX_WIDTH-1:0]         ocol_reg;
    logic signed [COST_FIELD_WIDTH-1:0] ototal_reg;
    logic [STATUS_WIDTH-1:0]            ostatus_reg;
    logic                               olast_reg;

    logic [CW-1:0]       kc;
    logic [RW-1:0]       kr;
    logic [RI-1:0]       ki;
    logic [W:0]          sub1_x, sub2_x, vsub_x, ssub_x, uadd_x, tadd_x;
    logic                ovf1, ovf2, upc_ovf, upr_ovf, sum_ovf;
    logic signed [W-1:0] red;
    logic                take;
    logic signed [W-1:0] sl;
    logic                better;
    logic                out_free;
    logic                load_ok;
    logic                load_err;
    logic                last_row;
    logic [AW:0]         scan_addr;
    logic [AW:0]         sum_addr;

    assign kc = k_reg[CW-1:0];
    assign kr = k_reg[RW-1:0];
    assign ki = k_reg[RI-1:0];

    assign sub1_x  = sub_ext(rd_data, u_reg[crow_reg]);
    assign ovf1    = sub1_x[W] ^ sub1_x[W-1];
    assign sub2_x  = sub_ext(t_reg, v_reg[kc]);
    assign ovf2    = sub2_x[W] ^ sub2_x[W-1];
    assign red     = $signed(sub2_x[W-1:0]);
    assign take    = !valid_reg[kc] || (red < slack_reg[kc]);
    assign sl      = take ? red : slack_reg[kc];
    assign better  = !have_reg || (sl < delta_reg);

    assign vsub_x  = sub_ext(v_reg[kc], delta_reg);
    assign ssub_x  = sub_ext(slack_reg[kc], delta_reg);
    assign upc_ovf = visited_reg[kc] ? (vsub_x[W] ^ vsub_x[W-1]) :
                     valid_reg[kc] ? (ssub_x[W] ^ ssub_x[W-1]) : 1'b0;
    assign uadd_x  = add_ext(u_reg[kr], delta_reg);
    assign upr_ovf = tree_reg[kr] && (uadd_x[W] ^ uadd_x[W-1]);
    assign tadd_x  = add_ext(total_reg, rd_data);
    assign sum_ovf = tadd_x[W] ^ tadd_x[W-1];

    assign scan_addr = (AW + 1)'(crow_reg - RW'(1)) * (AW + 1)'(nc_reg) +
                       (AW + 1)'(k_reg - KW'(1));
    assign sum_addr  = (AW + 1)'(k_reg) * (AW + 1)'(nc_reg) + (AW + 1)'(col_of_row_reg[ki]);

    assign out_free = !ovalid_reg || out_ch.ready;
    assign last_row = (k_reg + KW'(1)) == KW'(nr_reg);
    assign busy     = !((state_reg == S_IDLE) || (state_reg == S_EMIT) || (state_reg == S_ERR));

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        row_next   = row_reg;
        cur_next   = cur_reg;
        crow_next  = crow_reg;
        stat_next  = stat_reg;
        nr_next    = nr_reg;
        nc_next    = nc_reg;
        job_pop    = 1'b0;
        load_ok    = 1'b0;
        load_err   = 1'b0;
        rd_addr    = AW'(sum_addr);
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop = 1'b1;
                    nr_next = RW'(job.rows);
                    nc_next = CW'(job.columns);
                    if (job.bad)
                    begin
                        stat_next  = STATUS_SHAPE;
                        state_next = S_ERR;
                    end
                    else
                    begin
                        state_next = S_CLR;
                    end
                end
            end
            S_CLR:
            begin
                row_next   = RW'(1);
                state_next = S_ROWI;
            end
            S_ROWI:
            begin
                cur_next   = '0;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                crow_next  = owner_reg[cur_reg];
                k_next     = KW'(1);
                state_next = S_SCA;
            end
            S_SCA:
            begin
                rd_addr = AW'(scan_addr);
                if (k_reg > KW'(nc_reg))
                begin
                    state_next = S_DEC;
                end
                else if (visited_reg[kc])
                begin
                    k_next = k_reg + KW'(1);
                end
                else
                begin
                    state_next = S_SCB;
                end
            end
            S_SCB:
            begin
                if (ovf1)
                begin
                    stat_next  = STATUS_OVERFLOW;
                    state_next = S_ERR;
                end
                else
                begin
                    state_next = S_SCC;
                end
            end
            S_SCC:
            begin
                if (ovf2)
                begin
                    stat_next  = STATUS_OVERFLOW;
                    state_next = S_ERR;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_SCA;
                end
            end
            S_DEC:
            begin
                if (!have_reg)
                begin
                    stat_next  = STATUS_SHAPE;
                    state_next = S_ERR;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_UPC;
                end
            end
            S_UPC:
            begin
                if (upc_ovf)
                begin
                    stat_next  = STATUS_OVERFLOW;
                    state_next = S_ERR;
                end
                else if (k_reg == KW'(nc_reg))
                begin
                    k_next     = KW'(1);
                    state_next = S_UPR;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            S_UPR:
            begin
                if (upr_ovf)
                begin
                    stat_next  = STATUS_OVERFLOW;
                    state_next = S_ERR;
                end
                else if (k_reg == KW'(nr_reg))
                begin
                    cur_next   = next_reg;
                    state_next = S_TEST;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            S_TEST:
            begin
                state_next = (owner_reg[cur_reg] == '0) ? S_FLIP : S_STEP;
            end
            S_FLIP:
            begin
                cur_next = pred_reg[cur_reg];
                if (pred_reg[cur_reg] == '0)
                begin
                    if (row_reg == nr_reg)
                    begin
                        k_next     = KW'(1);
                        state_next = S_ASGN;
                    end
                    else
                    begin
                        row_next   = row_reg + RW'(1);
                        state_next = S_ROWI;
                    end
                end
            end
            S_ASGN:
            begin
                if (k_reg == KW'(nc_reg))
                begin
                    k_next     = '0;
                    state_next = S_SUMA;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            S_SUMA:
            begin
                state_next = S_SUMB;
            end
            S_SUMB:
            begin
                if (sum_ovf)
                begin
                    stat_next  = STATUS_OVERFLOW;
                    state_next = S_ERR;
                end
                else if (last_row)
                begin
                    k_next     = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_SUMA;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    load_ok = 1'b1;
                    if (last_row)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + KW'(1);
                    end
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    load_err   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ovalid_next = (load_ok || load_err) ? 1'b1 : (out_ch.ready ? 1'b0 : ovalid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            k_reg      <= '0;
            row_reg    <= '0;
            cur_reg    <= '0;
            crow_reg   <= '0;
            stat_reg   <= STATUS_OK;
            nr_reg     <= '0;
            nc_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            row_reg    <= row_next;
            cur_reg    <= cur_next;
            crow_reg   <= crow_next;
            stat_reg   <= stat_next;
            nr_reg     <= nr_next;
            nc_reg     <= nc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_CLR:
            begin
                for (int i = 0; i <= MAX_ROWS; i++)
                begin
                    u_reg[i] <= '0;
                end
                for (int i = 0; i <= MAX_COLUMNS; i++)
                begin
                    v_reg[i]     <= '0;
                    owner_reg[i] <= '0;
                    pred_reg[i]  <= '0;
                end
            end
            S_ROWI:
            begin
                owner_reg[0] <= row_reg;
                valid_reg    <= '0;
                visited_reg  <= '0;
                tree_reg     <= '0;
            end
            S_STEP:
            begin
                visited_reg[cur_reg]          <= 1'b1;
                tree_reg[owner_reg[cur_reg]]  <= 1'b1;
                have_reg                      <= 1'b0;
            end
            S_SCB:
            begin
                t_reg <= $signed(sub1_x[W-1:0]);
            end
            S_SCC:
            begin
                if (!ovf2)
                begin
                    if (take)
                    begin
                        slack_reg[kc] <= red;
                        valid_reg[kc] <= 1'b1;
                        pred_reg[kc]  <= cur_reg;
                    end
                    if (better)
                    begin
                        delta_reg <= sl;
                        next_reg  <= kc;
                        have_reg  <= 1'b1;
                    end
                end
            end
            S_UPC:
            begin
                if (visited_reg[kc])
                begin
                    v_reg[kc] <= $signed(vsub_x[W-1:0]);
                end
                else if (valid_reg[kc])
                begin
                    slack_reg[kc] <= $signed(ssub_x[W-1:0]);
                end
            end
            S_UPR:
            begin
                if (tree_reg[kr])
                begin
                    u_reg[kr] <= $signed(uadd_x[W-1:0]);
                end
            end
            S_FLIP:
            begin
                owner_reg[cur_reg] <= owner_reg[pred_reg[cur_reg]];
            end
            S_ASGN:
            begin
                total_reg <= '0;
                if (owner_reg[kc] != '0)
                begin
                    col_of_row_reg[RI'(owner_reg[kc] - RW'(1))] <= kc - CW'(1);
                end
            end
            S_SUMB:
            begin
                total_reg <= $signed(tadd_x[W-1:0]);
            end
            default:
            begin
            end
        endcase
        if (load_ok)
        begin
            orow_reg    <= OUT_INDEX_WIDTH'(k_reg);
            ocol_reg    <= OUT_INDEX_WIDTH'(col_of_row_reg[ki]);
            ototal_reg  <= COST_FIELD_WIDTH'(total_reg);
            ostatus_reg <= STATUS_OK;
            olast_reg   <= last_row;
        end
        else if (load_err)
        begin
            orow_reg    <= '0;
            ocol_reg    <= '0;
            ototal_reg  <= '0;
            ostatus_reg <= stat_reg;
            olast_reg   <= 1'b1;
        end
    end

    assign out_ch.valid           = ovalid_reg;
    assign out_ch.row_index       = orow_reg;
    assign out_ch.assigned_column = ocol_reg;
    assign out_ch.total_cost      = ototal_reg;
    assign out_ch.status          = ostatus_reg;
    assign out_ch.last_result     = olast_reg;

endmodule

// File: design/hungarian_min_cost_assignment_top.sv
// Top level of the minimum-cost assignment block.
// Usage: set rows_in_use (index 0) and columns_in_use (index 1) on the cfg write
// port while the block is idle; both reset to 1. Then send the cost matrix in
// row-major order on in_ch, one signed cost per item, last_entry set on the
// final one. in_ch accepts one item per cycle while loading.
// After the final item the solver runs; each path step scans unvisited columns
// through the single read port of the matrix store, then updates the column
// potentials and slacks and then the row potentials, with overflow checks.
// Results leave on out_ch: one item per row in row order with the column and the
// total cost, or a single error item (overflow or bad shape); last_result marks
// the end of a run. in_ch stays low on ready while a solve is under way; the
// next matrix may load while results of the previous run drain.
// A stalled receiver holds the current result in the output register and halts
// the emission of further rows. Reset clears the load count, the queue and the
// solver; the matrix store keeps no reset value.
module hungarian_min_cost_assignment_top import hmca_pkg::*; #(
    parameter int MAX_ROWS    = 16,
    parameter int MAX_COLUMNS = 16,
    parameter int COST_WIDTH  = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    hmca_in_if.sink              in_ch,
    hmca_out_if.source           out_ch,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CFG_WIDTH-1:0]         rows_reg;
    logic [CFG_WIDTH-1:0]         columns_reg;
    logic                         back_busy;
    logic                         push_valid;
    logic                         push_ready;
    job_t                         push_job;
    logic                         pop_valid;
    logic                         pop_ready;
    job_t                         pop_job;
    logic [AW-1:0]                rd_addr;
    logic signed [COST_WIDTH-1:0] rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg    <= CFG_WIDTH'(1);
            columns_reg <= CFG_WIDTH'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS:    rows_reg    <= cfg_data;
                CFG_COLUMNS: columns_reg <= cfg_data;
                default:     rows_reg    <= rows_reg;
            endcase
        end
    end

    hmca_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .COST_WIDTH  (COST_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .rows_in_use    (rows_reg),
        .columns_in_use (columns_reg),
        .back_busy      (back_busy),
        .queue_empty    (!pop_valid),
        .push_valid     (push_valid),
        .push_job       (push_job),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data)
    );

    hmca_job_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    hmca_back #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .COST_WIDTH  (COST_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_pop   (pop_ready),
        .job       (pop_job),
        .busy      (back_busy),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_ch    (out_ch)
    );

endmodule

// File: design/hmca_checker.sv
// Port-level checks of the minimum-cost assignment block and their binding.
module hmca_checker import hmca_pkg::*; (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [OUT_INDEX_WIDTH-1:0]         row_index,
    input logic [OUT_INDEX_WIDTH-1:0]         assigned_column,
    input logic signed [COST_FIELD_WIDTH-1:0] total_cost,
    input logic [STATUS_WIDTH-1:0]            status,
    input logic                               last_result
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
        $stable({row_index, assigned_column, total_cost, status, last_result}))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK) || (status == STATUS_OVERFLOW) ||
        (status == STATUS_SHAPE))
        else $error("unknown status code");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |-> last_result && (row_index == '0) &&
        (assigned_column == '0) && (total_cost == '0))
        else $error("error item not single and cleared");

    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_result |=> out_valid &&
        (row_index == $past(row_index) + OUT_INDEX_WIDTH'(1)))
        else $error("row results not contiguous");

endmodule

bind hungarian_min_cost_assignment_top hmca_checker u_hmca_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .row_index       (out_ch.row_index),
    .assigned_column (out_ch.assigned_column),
    .total_cost      (out_ch.total_cost),
    .status          (out_ch.status),
    .last_result     (out_ch.last_result)
);

// File: tb/sv/hmca_assignment_checker.sv
`timescale 1ns / 1ps
// Watches the item channels and config port, predicts the assignment results and compares them.
module hmca_assignment_checker import hmca_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    hmca_in_if   in_mon,
    hmca_out_if  out_mon,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    output int   failures,
    output int   pending,
    output int   results_seen,
    output int   error_results
);

    localparam int STORE_DEPTH = 256;
    localparam longint COST_HI = 64'sd2147483647;
    localparam longint COST_LO = -64'sd2147483648;

    typedef struct {
        logic [OUT_INDEX_WIDTH-1:0]         row_index;
        logic [OUT_INDEX_WIDTH-1:0]         assigned_column;
        logic signed [COST_FIELD_WIDTH-1:0] total_cost;
        logic [STATUS_WIDTH-1:0]            status;
        logic                               last_result;
    } assignment_t;

    assignment_t assignment_q[$];

    logic [CFG_WIDTH-1:0] rows_cfg, columns_cfg;
    longint cost_mem[STORE_DEPTH];
    int     entry_count;
    longint row_pot[17], col_pot[17], slack[17];
    int     owner[17], pred[17], chosen[16];
    bit     slack_ok[17], visited[17], ovf;
    longint total_sum;

    function automatic longint add_checked(longint a, longint b);
        if ((b > 0 && a > COST_HI - b) || (b < 0 && a < COST_LO - b))
        begin
            ovf = 1'b1;
            return 0;
        end
        return a + b;
    endfunction

    function automatic longint sub_checked(longint a, longint b);
        if ((b > 0 && a < COST_LO + b) || (b < 0 && a > COST_HI + b))
        begin
            ovf = 1'b1;
            return 0;
        end
        return a - b;
    endfunction

    function automatic int solve_assignment(int nr, int nc);
        int cur, crow, nxt, prv, o;
        bit have_delta;
        longint delta, red;
        ovf = 1'b0;
        for (int j = 0; j < 17; j++)
        begin
            row_pot[j] = 0;
            col_pot[j] = 0;
            owner[j] = 0;
            pred[j] = 0;
        end
        for (int r = 1; r <= nr; r++)
        begin
            cur = 0;
            owner[0] = r;
            for (int j = 0; j < 17; j++)
            begin
                slack_ok[j] = 1'b0;
                visited[j] = 1'b0;
            end
            do
            begin
                crow = owner[cur];
                have_delta = 1'b0;
                delta = 0;
                nxt = 0;
                visited[cur] = 1'b1;
                for (int j = 1; j <= nc; j++)
                begin
                    if (visited[j])
                        continue;
                    red = cost_mem[(crow - 1) * nc + (j - 1)];
                    red = sub_checked(red, row_pot[crow]);
                    red = sub_checked(red, col_pot[j]);
                    if (ovf)
                        return STATUS_OVERFLOW;
                    if (!slack_ok[j] || red < slack[j])
                    begin
                        slack[j] = red;
                        slack_ok[j] = 1'b1;
                        pred[j] = cur;
                    end
                    if (!have_delta || slack[j] < delta)
                    begin
                        delta = slack[j];
                        have_delta = 1'b1;
                        nxt = j;
                    end
                end
                if (!have_delta)
                    return STATUS_SHAPE;
                for (int j = 0; j <= nc; j++)
                begin
                    if (visited[j])
                    begin
                        o = owner[j];
                        row_pot[o] = add_checked(row_pot[o], delta);
                        col_pot[j] = sub_checked(col_pot[j], delta);
                    end
                    else if (slack_ok[j])
                        slack[j] = sub_checked(slack[j], delta);
                    if (ovf)
                        return STATUS_OVERFLOW;
                end
                cur = nxt;
            end
            while (owner[cur] != 0);
            do
            begin
                prv = pred[cur];
                owner[cur] = owner[prv];
                cur = prv;
            end
            while (cur != 0);
        end
        for (int r = 0; r < nr; r++)
            chosen[r] = 0;
        for (int j = 1; j <= nc; j++)
            if (owner[j] != 0)
                chosen[owner[j] - 1] = j - 1;
        total_sum = 0;
        for (int r = 0; r < nr; r++)
        begin
            total_sum = add_checked(total_sum, cost_mem[r * nc + chosen[r]]);
            if (ovf)
                return STATUS_OVERFLOW;
        end
        return STATUS_OK;
    endfunction

    task automatic push_result(int r, int c, longint tot, logic [STATUS_WIDTH-1:0] st,
                               logic lst);
        assignment_t a;
        a.row_index = r[OUT_INDEX_WIDTH-1:0];
        a.assigned_column = c[OUT_INDEX_WIDTH-1:0];
        a.total_cost = tot[COST_FIELD_WIDTH-1:0];
        a.status = st;
        a.last_result = lst;
        assignment_q.push_back(a);
    endtask

    task automatic take_entry(logic signed [COST_FIELD_WIDTH-1:0] c, logic lst);
        int nr, nc, rc;
        nr = rows_cfg;
        nc = columns_cfg;
        if (entry_count < STORE_DEPTH)
            cost_mem[entry_count] = longint'(c);
        if (entry_count <= STORE_DEPTH)
            entry_count++;
        if (!lst)
            return;
        if (nr == 0 || nr > 16 || nc == 0 || nc > 16 || nr > nc || entry_count != nr * nc)
        begin
            entry_count = 0;
            push_result(0, 0, 0, STATUS_SHAPE, 1'b1);
            return;
        end
        entry_count = 0;
        rc = solve_assignment(nr, nc);
        if (rc != STATUS_OK)
        begin
            push_result(0, 0, 0, rc[STATUS_WIDTH-1:0], 1'b1);
            return;
        end
        for (int r = 0; r < nr; r++)
            push_result(r, chosen[r], total_sum, STATUS_OK, r + 1 == nr);
    endtask

    task automatic check_result();
        assignment_t e;
        results_seen++;
        if (out_mon.status != STATUS_OK)
            error_results++;
        if (assignment_q.size() == 0)
        begin
            $display("%0t: unexpected result row %0d col %0d total %0d status %0d last %0b",
                     $time, out_mon.row_index, out_mon.assigned_column, out_mon.total_cost,
                     out_mon.status, out_mon.last_result);
            failures++;
            return;
        end
        e = assignment_q.pop_front();
        if (e.row_index !== out_mon.row_index || e.assigned_column !== out_mon.assigned_column
            || e.total_cost !== out_mon.total_cost || e.status !== out_mon.status
            || e.last_result !== out_mon.last_result)
        begin
            $display("%0t: mismatch expected row %0d col %0d total %0d status %0d last %0b",
                     $time, e.row_index, e.assigned_column, e.total_cost, e.status,
                     e.last_result);
            $display("%0t:          actual   row %0d col %0d total %0d status %0d last %0b",
                     $time, out_mon.row_index, out_mon.assigned_column, out_mon.total_cost,
                     out_mon.status, out_mon.last_result);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg <= 5'd1;
            columns_cfg <= 5'd1;
            entry_count = 0;
            assignment_q.delete();
            failures <= 0;
            pending <= 0;
            results_seen = 0;
            error_results = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ROWS)
                    rows_cfg <= cfg_data;
                else
                    columns_cfg <= cfg_data;
            end
            if (out_mon.valid && out_mon.ready)
                check_result();
            if (in_mon.valid && in_mon.ready)
                take_entry(in_mon.cost, in_mon.last_entry);
            pending <= assignment_q.size();
        end
    end

endmodule

// File: tb/sv/hungarian_min_cost_assignment_top_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the minimum-cost assignment block.
module hungarian_min_cost_assignment_top_tb;
    import hmca_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_WIDTH-1:0] cfg_data;
    int failures, pending, results_seen, error_results;
    int entries_sent, matrices_sent;
    int hold_cycles;
    bit fast;

    hmca_in_if  in_ch ();
    hmca_out_if out_ch ();

    hungarian_min_cost_assignment_top uut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    hmca_assignment_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .failures(failures), .pending(pending), .results_seen(results_seen),
        .error_results(error_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("hungarian_min_cost_assignment_top_tb: errors");
        $finish;
    end

    function automatic int draw_gap();
        return fast ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic logic signed [31:0] draw_cost(bit wide);
        if (wide)
            return $urandom;
        return int'($urandom_range(0, 2000)) - 1000;
    endfunction

    // call and return at a rising edge
    task automatic send_entry(logic signed [31:0] c, logic lst);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cost <= c;
        in_ch.last_entry <= lst;
        do @(negedge clk); while (!in_ch.ready);
        @(posedge clk);
        entries_sent++;
        if (lst)
            matrices_sent++;
    endtask

    task automatic send_matrix(int n, bit wide);
        for (int k = 0; k < n; k++)
            send_entry(draw_cost(wide), k == n - 1);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_shape(logic [CFG_WIDTH-1:0] r, logic [CFG_WIDTH-1:0] c);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_ROWS;
        cfg_data <= r;
        @(posedge clk);
        cfg_index <= CFG_COLUMNS;
        cfg_data <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = draw_gap();
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(negedge clk); while (!out_ch.valid);
        end
    end

    initial
    begin
        int r, c, n, pick, reps;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ROWS;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.cost = '0;
        in_ch.last_entry = 1'b0;
        hold_cycles = 0;
        fast = 1'b0;
        entries_sent = 0;
        matrices_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_entry(32'sh7fffffff, 1'b1);
        send_entry(32'sh80000000, 1'b1);
        set_shape(5'd1, 5'd2);
        send_entry(32'sh7fffffff, 1'b0);
        send_entry(32'sh80000000, 1'b1);
        set_shape(5'd2, 5'd2);
        send_entry(32'sh7fffffff, 1'b0);
        send_entry(32'sh7ffffff0, 1'b0);
        send_entry(32'sh00000005, 1'b0);
        send_entry(-32'sd7, 1'b1);
        send_matrix(3, 1'b0);
        set_shape(5'd2, 5'd1);
        send_matrix(2, 1'b0);
        set_shape(5'd0, 5'd1);
        send_matrix(1, 1'b0);
        set_shape(5'd31, 5'd31);
        send_matrix(1, 1'b0);
        set_shape(5'd16, 5'd16);
        send_matrix(2, 1'b0);
        set_shape(5'd1, 5'd16);
        send_matrix(16, 1'b1);

        set_shape(5'd3, 5'd4);
        fast = 1'b1;
        send_matrix(12, 1'b0);
        hold_cycles = 400;
        send_matrix(12, 1'b0);
        send_matrix(12, 1'b0);
        send_matrix(12, 1'b1);
        fast = 1'b0;

        while (entries_sent < 155)
        begin
            r = $urandom_range(1, 5);
            c = $urandom_range(r, 6);
            pick = $urandom_range(0, 19);
            if (pick == 0 && c < 16)
                r = c + 1;
            fast = ($urandom_range(0, 5) == 0);
            set_shape(r[CFG_WIDTH-1:0], c[CFG_WIDTH-1:0]);
            reps = $urandom_range(1, 3);
            for (int m = 0; m < reps; m++)
            begin
                n = r * c;
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    n = n - 1 > 0 ? n - 1 : 1;
                else if (pick == 1)
                    n = n + 1;
                send_matrix(n, $urandom_range(0, 5) == 0);
            end
        end
        fast = 1'b0;
        settle();

        $display("sent %0d entries in %0d matrices over varied shapes and stalls",
                 entries_sent, matrices_sent);
        $display("checked %0d results, %0d of them overflow or shape errors",
                 results_seen, error_results);
        if (failures == 0)
            $display("hungarian_min_cost_assignment_top_tb: clean");
        else
            $display("hungarian_min_cost_assignment_top_tb: errors");
        $finish;
    end

endmodule

// File: hungarian_min_cost_assignment_top.f
design/hmca_pkg.sv
design/hmca_channels.sv
design/hmca_front.sv
design/hmca_job_queue.sv
design/hmca_back.sv
design/hungarian_min_cost_assignment_top.sv
design/hmca_checker.sv
tb/sv/hmca_assignment_checker.sv
tb/sv/hungarian_min_cost_assignment_top_tb.sv
